// File: rtl/iotr_pkg.sv
// Shared constants and controller/datapath interface types for the object table RAM port.
package iotr_pkg;

  localparam int unsigned AddrW = 13;
  localparam int unsigned DataW = 8;
  localparam int unsigned RamDepth = 8192;
  localparam int unsigned IdxW = 7;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Window addresses
  localparam logic [AddrW-1:0] WIN_REC0  = 13'h1ff0;
  localparam logic [AddrW-1:0] WIN_ATTR  = 13'h1ff4;
  localparam logic [AddrW-1:0] WIN_BASE  = 13'h1ff5;
  localparam logic [AddrW-1:0] WIN_INDEX = 13'h1ff6;

  // Table bases and attribute offset
  localparam logic [AddrW-1:0] BASE_UPPER  = 13'h1800;
  localparam logic [AddrW-1:0] BASE_LOWER  = 13'h1c00;
  localparam logic [AddrW-1:0] ATTR_OFFSET = 13'h0200;
  localparam logic [AddrW-1:0] CLEAR_LAST  = 13'h1fff;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step; // write zero at the clear pointer and advance it
    logic accept;     // capture an input transfer and start its RAM access
    logic finish;     // RAM read data is back: capture it or write the merged byte
    logic push;       // load the result into the output register
  } iotr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;   // clear pointer is at the last byte
    logic direct_write; // input item is a write that needs no read
    logic out_free;     // output register can take a result this cycle
  } iotr_sts_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_PUSH  = 4'b1000
  } iotr_state_t;

endpackage

// File: rtl/iotr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iotr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/iotr_ctrl.sv
// Controller state machine: clear pass, access sequencing and result hand-off.
module iotr_ctrl import iotr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  iotr_sts_t sts,
  output iotr_cmd_t cmd
);

  iotr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.direct_write ? S_PUSH : S_READ;
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/iotr_dp.sv
// Datapath: address decode, table address generation, RAM, attribute merge, output register.
module iotr_dp import iotr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             func,
  input  logic [AddrW-1:0] bus_addr,
  input  logic [DataW-1:0] wdata,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DataW-1:0] rdata,
  input  iotr_cmd_t        cmd,
  output iotr_sts_t        sts
);

  logic [AddrW-1:0] clr_ptr;
  logic             upper_base_sel;
  logic [IdxW-1:0]  record_index;

  logic             is_wr_attr;
  logic             is_rd;
  logic [AddrW-1:0] acc_addr;
  logic [1:0]       fld_sel;
  logic [1:0]       fld_bits;
  logic [DataW-1:0] hold;

  logic             win_rec;
  logic             win_attr;
  logic [AddrW-1:0] base;
  logic [AddrW-1:0] rec_addr;
  logic [AddrW-1:0] attr_addr;
  logic [AddrW-1:0] eff_addr;
  logic [DataW-1:0] fld_mask;
  logic [DataW-1:0] merged;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [DataW-1:0] ram_rdata;

  // Window decode and table address generation
  assign win_rec   = (bus_addr[AddrW-1:2] == WIN_REC0[AddrW-1:2]);
  assign win_attr  = (bus_addr == WIN_ATTR);
  assign base      = upper_base_sel ? BASE_UPPER : BASE_LOWER;
  assign rec_addr  = base + {{(AddrW-IdxW-2){1'b0}}, record_index, bus_addr[1:0]};
  assign attr_addr = base + ATTR_OFFSET + {{(AddrW-IdxW+2){1'b0}}, record_index[IdxW-1:2]};
  assign eff_addr  = win_rec ? rec_addr : (win_attr ? attr_addr : bus_addr);

  // Two-bit attribute field merge
  assign fld_mask = 8'h03 << {fld_sel, 1'b0};
  assign merged   = (ram_rdata & ~fld_mask) | ({6'd0, fld_bits} << {fld_sel, 1'b0});

  // RAM write port: clear pass, direct write at accept, merged byte on finish
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = eff_addr;
    ram_wdata = wdata;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_ptr;
      ram_wdata = '0;
    end else if (cmd.finish) begin
      ram_we    = is_wr_attr;
      ram_waddr = acc_addr;
      ram_wdata = merged;
    end else if (cmd.accept) begin
      ram_we    = (func == FUNC_WRITE) && !win_attr;
    end
  end

  iotr_ram #(
    .WIDTH (DataW),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (eff_addr),
    .rdata (ram_rdata)
  );

  // Clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear_step) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // Base select and record index
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_base_sel <= 1'b0;
      record_index   <= '0;
    end else if (cmd.accept && (func == FUNC_WRITE)) begin
      if (bus_addr == WIN_BASE) begin
        upper_base_sel <= wdata[0];
      end
      if (bus_addr == WIN_INDEX) begin
        record_index <= wdata[IdxW-1:0];
      end
    end
  end

  // Captured access and result byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_wr_attr <= (func == FUNC_WRITE) && win_attr;
      is_rd      <= (func != FUNC_WRITE);
      acc_addr   <= eff_addr;
      fld_sel    <= record_index[1:0];
      fld_bits   <= wdata[1:0];
      hold       <= '0;
    end else if (cmd.finish && is_rd) begin
      hold <= ram_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rdata <= hold;
    end
  end

  // Status
  assign sts.clear_last   = (clr_ptr == CLEAR_LAST);
  assign sts.direct_write = (func == FUNC_WRITE) && !win_attr;
  assign sts.out_free     = !out_valid || !out_stall;

endmodule

// File: rtl/indexed_object_table_ram_port.sv
// Top level of the indexed object table RAM port.
//
// Byte bus slave over an 8 KiB RAM. Input channel (in_valid / in_stall) carries
// one access: func (0 read, 1 write), bus_addr and wdata. Output channel
// (out_valid / out_stall) returns one rdata byte per access, zero for writes.
// Addresses 0x1ff0..0x1ff4 are windows into an object table; 0x1ff5 and 0x1ff6
// set the table base and record index.
// Sequencing: a write that needs no read goes from accept straight to the
// push state; reads and the attribute read-modify-write first pass through
// the read state for the registered read of the single RAM read port. One
// access is in flight at a time; a new one is taken while the previous
// result waits. Reset: rst clears the control state, then a clear pass
// writes zero to all 8192 RAM bytes, one a cycle; in_stall is high throughout.
// When the receiver stalls, the result holds in the output register; the
// following access completes up to its hand-off and then waits.
module indexed_object_table_ram_port import iotr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [AddrW-1:0] bus_addr,
  input  logic [DataW-1:0] wdata,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DataW-1:0] rdata
);

  iotr_cmd_t cmd;
  iotr_sts_t sts;

  iotr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iotr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .bus_addr  (bus_addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (rdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
